// ----- hdl/sli_pkg.sv -----
// sorted list intersection: shared constants and types
// no dependencies

package sli_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int ADDR_W     = $clog2(LIST_DEPTH);
	localparam int LEN_W      = $clog2(LIST_DEPTH + 1);
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 7;
	localparam int OP_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_LEFT  = 2'd0,
		OP_LOAD_RIGHT = 2'd1,
		OP_RUN        = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

endpackage

// ----- hdl/sli_in_if.sv -----
// sorted list intersection: command channel, one load, run or clear per item
// depends on sli_pkg

interface sli_in_if;
	import sli_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         opcode;
	logic signed [VAL_W-1:0] element_value;

	modport source(output valid, opcode, element_value, input ready);
	modport sink(input valid, opcode, element_value, output ready);
endinterface

// ----- hdl/sli_out_if.sv -----
// sorted list intersection: result channel, one match or empty mark per item
// depends on sli_pkg

interface sli_out_if;
	import sli_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] common_value;
	logic [CNT_W-1:0]        match_count;
	logic                    is_empty;
	logic                    overflow_seen;
	logic                    last_of_run;

	modport source(output valid, common_value, match_count, is_empty, overflow_seen,
		last_of_run, input ready);
	modport sink(input valid, common_value, match_count, is_empty, overflow_seen,
		last_of_run, output ready);
endinterface

// ----- hdl/sli_list_store.sv -----
// sorted list intersection: one list store, single write port, registered read
// depends on sli_pkg

module sli_list_store (
	input  logic                             clk,
	input  logic                             we,
	input  logic [sli_pkg::ADDR_W-1:0]       waddr,
	input  logic signed [sli_pkg::VAL_W-1:0] wdata,
	input  logic [sli_pkg::ADDR_W-1:0]       raddr,
	output logic signed [sli_pkg::VAL_W-1:0] rdata
);
	import sli_pkg::*;

	logic signed [VAL_W-1:0] mem [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/sorted_list_intersection_core.sv -----
// sorted list intersection: top level, command decode, two-pointer merge walk
// depends on sli_pkg, sli_in_if, sli_out_if, sli_list_store
//
// usage:
//   cmd carries one item per command: load left, load right, run, clear.
//   a load appends element_value to its list; a load into a
//   full list is dropped and sets the sticky overflow flag.
//   clear empties both lists and drops the overflow flag.
//   a run walks both lists out of the registered read ports of the two
//   stores, one element compare per cycle while res does not stall, and
//   emits one res item per common value, or a single empty item; the final
//   item has last_of_run. the first result leaves once the second match
//   or the end of the walk is found.
//   cmd is not ready during a run.
//   res has an output register: when the receiver stalls, the walk halts
//   at the next match until the register frees, and nothing is lost.
//   reset empties both lists, clears the flag and drops any pending item;
//   store contents are not cleared and are only read below the length.

module sorted_list_intersection_core (
	input logic       clk,
	input logic       arst_n,
	sli_in_if.sink    cmd,
	sli_out_if.source res
);
	import sli_pkg::*;

	state_t state_q, state_d;

	logic [LEN_W-1:0] left_len_q, left_len_d;
	logic [LEN_W-1:0] right_len_q, right_len_d;
	logic             ovf_q, ovf_d;
	logic [LEN_W-1:0] i_q, i_d;
	logic [LEN_W-1:0] j_q, j_d;

	logic                    pend_valid_q, pend_valid_d;
	logic signed [VAL_W-1:0] pend_value_q, pend_value_d;
	logic [CNT_W-1:0]        pend_count_q, pend_count_d;

	logic                    left_we, right_we;
	logic signed [VAL_W-1:0] left_rd, right_rd;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [CNT_W-1:0]        out_count_q;
	logic                    out_empty_q, out_ovf_q, out_last_q;

	logic                    slot_free;
	logic                    push;
	logic signed [VAL_W-1:0] push_value;
	logic [CNT_W-1:0]        push_count;
	logic                    push_empty, push_last;
	op_t                     op;

	assign op        = op_t'(cmd.opcode);
	assign slot_free = !out_valid_q || res.ready;

	sli_list_store u_left (
		.clk  (clk),
		.we   (left_we),
		.waddr(left_len_q[ADDR_W-1:0]),
		.wdata(cmd.element_value),
		.raddr(i_d[ADDR_W-1:0]),
		.rdata(left_rd)
	);

	sli_list_store u_right (
		.clk  (clk),
		.we   (right_we),
		.waddr(right_len_q[ADDR_W-1:0]),
		.wdata(cmd.element_value),
		.raddr(j_d[ADDR_W-1:0]),
		.rdata(right_rd)
	);

	always_comb begin
		state_d      = state_q;
		left_len_d   = left_len_q;
		right_len_d  = right_len_q;
		ovf_d        = ovf_q;
		i_d          = i_q;
		j_d          = j_q;
		pend_valid_d = pend_valid_q;
		pend_value_d = pend_value_q;
		pend_count_d = pend_count_q;
		left_we      = 1'b0;
		right_we     = 1'b0;
		cmd.ready    = 1'b0;
		push         = 1'b0;
		push_value   = '0;
		push_count   = '0;
		push_empty   = 1'b0;
		push_last    = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				i_d       = '0;
				j_d       = '0;
				if (cmd.valid) begin
					unique case (op)
						OP_LOAD_LEFT: begin
							if (left_len_q == LEN_W'(LIST_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								left_we    = 1'b1;
								left_len_d = left_len_q + LEN_W'(1);
							end
						end
						OP_LOAD_RIGHT: begin
							if (right_len_q == LEN_W'(LIST_DEPTH)) begin
								ovf_d = 1'b1;
							end else begin
								right_we    = 1'b1;
								right_len_d = right_len_q + LEN_W'(1);
							end
						end
						OP_RUN: begin
							state_d      = ST_WALK;
							pend_valid_d = 1'b0;
							pend_count_d = '0;
						end
						OP_CLEAR: begin
							left_len_d  = '0;
							right_len_d = '0;
							ovf_d       = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WALK: begin
				if (i_q >= left_len_q || j_q >= right_len_q) begin
					state_d = ST_FINISH;
				end else if (left_rd < right_rd) begin
					i_d = i_q + LEN_W'(1);
				end else if (right_rd < left_rd) begin
					j_d = j_q + LEN_W'(1);
				end else if (!pend_valid_q || slot_free) begin
					if (pend_valid_q) begin
						push       = 1'b1;
						push_value = pend_value_q;
						push_count = pend_count_q;
					end
					pend_valid_d = 1'b1;
					pend_value_d = left_rd;
					pend_count_d = pend_count_q + CNT_W'(1);
					i_d          = i_q + LEN_W'(1);
					j_d          = j_q + LEN_W'(1);
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					if (pend_valid_q) begin
						push_value = pend_value_q;
						push_count = pend_count_q;
					end else begin
						push_empty = 1'b1;
					end
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			left_len_q   <= '0;
			right_len_q  <= '0;
			ovf_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
			pend_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			left_len_q   <= left_len_d;
			right_len_q  <= right_len_d;
			ovf_q        <= ovf_d;
			i_q          <= i_d;
			j_q          <= j_d;
			pend_valid_q <= pend_valid_d;
			pend_count_q <= pend_count_d;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_value_q <= pend_value_d;
		if (push) begin
			out_value_q <= push_value;
			out_count_q <= push_count;
			out_empty_q <= push_empty;
			out_ovf_q   <= ovf_q;
			out_last_q  <= push_last;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.common_value  = out_value_q;
	assign res.match_count   = out_count_q;
	assign res.is_empty      = out_empty_q;
	assign res.overflow_seen = out_ovf_q;
	assign res.last_of_run   = out_last_q;
endmodule
